// File: design/apsp_pkg.sv
package apsp_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VTX_W = 4;
	localparam int CNT_W = 5;
	localparam int DIST_W = 16;
	localparam int ADDR_W = 2 * VTX_W;
	localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
	localparam logic [DIST_W-1:0] INF = {DIST_W{1'b1}};

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_RUN = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	typedef logic [VTX_W-1:0] vtx_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic load;
		logic piv_rd;
		logic piv_latch;
		logic row_rd;
		logic q_init;
		logic q_rd;
		logic out_load;
		logic out_query;
		vtx_t k;
		vtx_t r;
		vtx_t c;
		vtx_t nm1;
	} dp_cmd_t;

	typedef struct packed {
		logic q_in_range;
	} dp_sts_t;

	function automatic dist_t sat_add(input dist_t a, input dist_t b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (a == INF || b == INF || s >= {1'b0, INF}) begin
			return INF;
		end
		return s[DIST_W-1:0];
	endfunction

	function automatic dist_t cell_init(input addr_t a);
		return (a[ADDR_W-1:VTX_W] == a[VTX_W-1:0]) ? '0 : INF;
	endfunction

endpackage

// File: design/all_pairs_shortest_path_core.sv
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: action; tdata: source_vertex, dest_vertex, edge_weight
// m_axis    out        tdata: distance, closest_vertex, done_res, zero fill
// cfg       in         cfg_wdata: vertex_count, written when cfg_we is high
//
// Clear and load edge go through execute and finish; a query in range through start, a
// scan of n columns (n is the vertex count), tail and finish, or start then finish
// when out of range; a run through pivot read, latch and a row scan per pivot and row.
// The run time is set by the single write port of the distance memory.
// Reset marks every matrix entry invalid, so it reads as its cleared value.
// A new item is taken while a result still waits; the next result holds until then.
module all_pairs_shortest_path_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // source_vertex, dest_vertex, edge_weight
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // distance, closest_vertex, done_res, zero fill
);
	import apsp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	dist_t out_dist;
	vtx_t out_near;

	apsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	apsp_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_src   (s_tdata[3:0]),
		.in_dst   (s_tdata[7:4]),
		.in_wt    (s_tdata[23:8]),
		.out_dist (out_dist),
		.out_near (out_near)
	);

	assign m_tdata = {3'b000, 1'b1, out_near, out_dist};

endmodule

// File: design/apsp_dpath.sv
module apsp_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  apsp_pkg::dp_cmd_t   cmd,
	output apsp_pkg::dp_sts_t   sts,
	input  apsp_pkg::vtx_t      in_src,
	input  apsp_pkg::vtx_t      in_dst,
	input  apsp_pkg::dist_t     in_wt,
	output apsp_pkg::dist_t     out_dist,
	output apsp_pkg::vtx_t      out_near
);
	import apsp_pkg::*;

	dist_t mem_q [CELLS];
	logic [CELLS-1:0] vld_q;

	vtx_t src_q, dst_q;
	dist_t wt_q;
	dist_t pivot_q, best_q, dist_q, out_dist_q;
	vtx_t near_q, out_near_q;

	addr_t a_addr, b_addr, a_addr_q, b_addr_q, wr_addr_s1;
	dist_t a_data_q, b_data_q, a_eff, b_eff, alt;
	logic a_vld_q, b_vld_q;
	logic row_s1, q_s1;
	vtx_t idx_s1;

	logic wr_en;
	addr_t wr_addr;
	dist_t wr_data;

	always_comb begin
		if (cmd.piv_rd) begin
			a_addr = {cmd.r, cmd.k};
		end else if (cmd.row_rd) begin
			a_addr = {cmd.k, cmd.c};
		end else begin
			a_addr = {src_q, cmd.c};
		end
		b_addr = cmd.row_rd ? {cmd.r, cmd.c} : {src_q, dst_q};
	end

	assign a_eff = a_vld_q ? a_data_q : cell_init(a_addr_q);
	assign b_eff = b_vld_q ? b_data_q : cell_init(b_addr_q);
	assign alt = sat_add(pivot_q, a_eff);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = wr_addr_s1;
		wr_data = alt;
		if (cmd.load) begin
			wr_en = 1'b1;
			wr_addr = {src_q, dst_q};
			wr_data = wt_q;
		end else if (row_s1 && alt < b_eff) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		a_data_q <= mem_q[a_addr];
		b_data_q <= mem_q[b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			row_s1 <= 1'b0;
			q_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			row_s1 <= cmd.row_rd;
			q_s1 <= cmd.q_rd;
		end
	end

	always_ff @(posedge clk) begin
		a_vld_q <= vld_q[a_addr];
		b_vld_q <= vld_q[b_addr];
		a_addr_q <= a_addr;
		b_addr_q <= b_addr;
		wr_addr_s1 <= {cmd.r, cmd.c};
		idx_s1 <= cmd.c;
		if (cmd.capture) begin
			src_q <= in_src;
			dst_q <= in_dst;
			wt_q <= in_wt;
		end
		if (cmd.piv_latch) begin
			pivot_q <= a_eff;
		end
		if (cmd.q_init) begin
			best_q <= INF;
			near_q <= src_q;
			dist_q <= INF;
		end else if (q_s1) begin
			dist_q <= b_eff;
			if (idx_s1 != src_q && a_eff < best_q) begin
				best_q <= a_eff;
				near_q <= idx_s1;
			end
		end
		if (cmd.out_load) begin
			out_dist_q <= cmd.out_query ? dist_q : '0;
			out_near_q <= cmd.out_query ? near_q : '0;
		end
	end

	assign sts.q_in_range = (src_q <= cmd.nm1) && (dst_q <= cmd.nm1);
	assign out_dist = out_dist_q;
	assign out_near = out_near_q;

endmodule

// File: design/apsp_ctrl.sv
module apsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_action,
	output logic                out_valid,
	input  logic                out_ready,
	output apsp_pkg::dp_cmd_t   cmd,
	input  apsp_pkg::dp_sts_t   sts
);
	import apsp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_PIV = 4'd2;
	localparam logic [3:0] S_LATCH = 4'd3;
	localparam logic [3:0] S_ROW = 4'd4;
	localparam logic [3:0] S_TAIL = 4'd5;
	localparam logic [3:0] S_QSTART = 4'd6;
	localparam logic [3:0] S_QSCAN = 4'd7;
	localparam logic [3:0] S_QTAIL = 4'd8;
	localparam logic [3:0] S_FIN = 4'd9;

	logic [3:0] state_q, state_d;
	logic [CNT_W-1:0] vcount_q;
	logic [1:0] act_q;
	vtx_t k_q, r_q, c_q, nm1;
	logic out_valid_q;
	logic accept;

	always_comb begin
		if (vcount_q == '0) begin
			nm1 = '0;
		end else if (vcount_q > CNT_W'(MAX_VERTICES)) begin
			nm1 = VTX_W'(MAX_VERTICES - 1);
		end else begin
			nm1 = VTX_W'(vcount_q - 1'b1);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.k = k_q;
		cmd.r = r_q;
		cmd.c = c_q;
		cmd.nm1 = nm1;
		cmd.out_query = (act_q == ACT_QUERY);
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					case (in_action)
						ACT_RUN: state_d = S_PIV;
						ACT_QUERY: state_d = S_QSTART;
						default: state_d = S_EXEC;
					endcase
				end
			end
			S_EXEC: begin
				cmd.clear = (act_q == ACT_CLEAR);
				cmd.load = (act_q == ACT_LOAD);
				state_d = S_FIN;
			end
			S_PIV: begin
				cmd.piv_rd = 1'b1;
				state_d = S_LATCH;
			end
			S_LATCH: begin
				cmd.piv_latch = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				if (c_q == nm1) begin
					state_d = (r_q == nm1 && k_q == nm1) ? S_TAIL : S_PIV;
				end
			end
			S_TAIL: state_d = S_FIN;
			S_QSTART: begin
				cmd.q_init = 1'b1;
				state_d = sts.q_in_range ? S_QSCAN : S_FIN;
			end
			S_QSCAN: begin
				cmd.q_rd = 1'b1;
				if (c_q == nm1) begin
					state_d = S_QTAIL;
				end
			end
			S_QTAIL: state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= CNT_W'(MAX_VERTICES);
			act_q <= ACT_CLEAR;
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (accept) begin
				act_q <= in_action;
				k_q <= '0;
				r_q <= '0;
				c_q <= '0;
			end
			if (cmd.row_rd || cmd.q_rd) begin
				if (c_q == nm1) begin
					c_q <= '0;
					if (cmd.row_rd) begin
						if (r_q == nm1) begin
							r_q <= '0;
							k_q <= k_q + 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: tb/all_pairs_shortest_path_core_tb.sv
module all_pairs_shortest_path_core_tb;
	import apsp_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 80;

	typedef struct {
		dist_t distance;
		vtx_t closest;
		logic done;
	} path_result_t;

	class path_scoreboard;
		dist_t dist_mem [MAX_VERTICES][MAX_VERTICES];
		logic [CNT_W-1:0] vertex_count;
		path_result_t pending_answers [$];
		int errors;

		function new();
			vertex_count = 5'd16;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			int r, c;
			for (r = 0; r < MAX_VERTICES; r++) begin
				for (c = 0; c < MAX_VERTICES; c++) begin
					dist_mem[r][c] = (r == c) ? '0 : INF;
				end
			end
		endfunction

		function int active_count();
			if (vertex_count == 0) begin
				return 1;
			end
			if (vertex_count > MAX_VERTICES) begin
				return MAX_VERTICES;
			end
			return int'(vertex_count);
		endfunction

		function dist_t path_sum(dist_t a, dist_t b);
			logic [DIST_W:0] total;
			if (a == INF || b == INF) begin
				return INF;
			end
			total = {1'b0, a} + {1'b0, b};
			return (total >= {1'b0, INF}) ? INF : total[DIST_W-1:0];
		endfunction

		function void relax(int n);
			int k, r, c;
			dist_t alt;
			for (k = 0; k < n; k++) begin
				for (r = 0; r < n; r++) begin
					for (c = 0; c < n; c++) begin
						alt = path_sum(dist_mem[r][k], dist_mem[k][c]);
						if (alt < dist_mem[r][c]) begin
							dist_mem[r][c] = alt;
						end
					end
				end
			end
		endfunction

		function void set_count(logic [CNT_W-1:0] value);
			vertex_count = value;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		function void apply_action(logic [1:0] act, vtx_t src, vtx_t dst, dist_t weight);
			path_result_t res;
			int n, i;
			dist_t best;
			n = active_count();
			res.distance = '0;
			res.closest = '0;
			res.done = 1'b1;
			case (act)
				ACT_CLEAR: begin
					wipe();
				end
				ACT_LOAD: begin
					dist_mem[src][dst] = weight;
				end
				ACT_RUN: begin
					relax(n);
				end
				default: begin
					res.closest = src;
					if (src < n && dst < n) begin
						res.distance = dist_mem[src][dst];
						best = INF;
						for (i = 0; i < n; i++) begin
							if (i != src && dist_mem[src][i] < best) begin
								best = dist_mem[src][i];
								res.closest = vtx_t'(i);
							end
						end
					end else begin
						res.distance = INF;
					end
				end
			endcase
			pending_answers.insert(pending_answers.size(), res);
		endfunction

		function void check_answer(logic [23:0] beat);
			path_result_t want;
			if (pending_answers.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", beat);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (beat[15:0] !== want.distance) begin
				$error("distance: expected %0d, actual %0d", want.distance, beat[15:0]);
				errors++;
			end
			if (beat[19:16] !== want.closest) begin
				$error("closest_vertex: expected %0d, actual %0d", want.closest, beat[19:16]);
				errors++;
			end
			if (beat[20] !== want.done) begin
				$error("done_res: expected %0b, actual %0b", want.done, beat[20]);
				errors++;
			end
			if (beat[23:21] !== 3'b000) begin
				$error("zero fill: expected 0, actual %0b", beat[23:21]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	path_scoreboard sb;
	logic calm;
	int sent;
	int cycles;

	all_pairs_shortest_path_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("all_pairs_shortest_path_core_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_answer(m_tdata);
		end
	end

	function automatic int pick_gap();
		int roll;
		if (calm) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic vtx_t pick_vertex(int n);
		if ($urandom_range(0, 9) == 0) begin
			return vtx_t'($urandom_range(0, MAX_VERTICES - 1));
		end
		return vtx_t'($urandom_range(0, n - 1));
	endfunction

	function automatic dist_t pick_weight();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return dist_t'($urandom_range(0, 20));
		end
		if (roll < 80) begin
			return dist_t'($urandom_range(0, 65535));
		end
		if (roll < 85) begin
			return dist_t'(INF - 1'b1);
		end
		if (roll < 90) begin
			return INF;
		end
		return dist_t'($urandom_range(30000, 65535));
	endfunction

	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					hold = pick_gap();
				end
			end
		end
	end

	task automatic send_item(logic [1:0] act, vtx_t src, vtx_t dst, dist_t weight);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= act;
		s_tdata <= {weight, dst, src};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.apply_action(act, src, dst, weight);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic set_vertex_count(logic [4:0] value);
		s_tvalid <= 1'b0;
		wait_idle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_count(value);
	endtask

	task automatic run_episode();
		int n, i, loads, queries;
		n = sb.active_count();
		if ($urandom_range(0, 99) < 15) begin
			loads = $urandom_range(3, 10);
			for (i = 0; i < loads; i++) begin
				send_item(2'($urandom_range(0, 3)), vtx_t'($urandom_range(0, 15)),
					vtx_t'($urandom_range(0, 15)), dist_t'($urandom_range(0, 65535)));
			end
			return;
		end
		send_item(ACT_CLEAR, vtx_t'($urandom_range(0, 15)), vtx_t'($urandom_range(0, 15)),
			pick_weight());
		loads = $urandom_range(1, 2 * n + 2);
		for (i = 0; i < loads; i++) begin
			send_item(ACT_LOAD, pick_vertex(n), pick_vertex(n), pick_weight());
		end
		send_item(ACT_RUN, pick_vertex(n), pick_vertex(n), pick_weight());
		queries = $urandom_range(2, n + 3);
		for (i = 0; i < queries; i++) begin
			send_item(ACT_QUERY, pick_vertex(n), pick_vertex(n), pick_weight());
		end
		if ($urandom_range(0, 1) == 1) begin
			loads = $urandom_range(1, n);
			for (i = 0; i < loads; i++) begin
				send_item(ACT_LOAD, pick_vertex(n), pick_vertex(n), pick_weight());
			end
			send_item(ACT_RUN, pick_vertex(n), pick_vertex(n), pick_weight());
			for (i = 0; i < queries; i++) begin
				send_item(ACT_QUERY, pick_vertex(n), pick_vertex(n), pick_weight());
			end
		end
	endtask

	initial begin
		logic [4:0] phase_counts [14];
		int p, phase_end;
		phase_counts = '{5'd2, 5'd0, 5'd5, 5'd31, 5'd3, 5'd16, 5'd4, 5'd1, 5'd7, 5'd17,
			5'd6, 5'd3, 5'd8, 5'd4};
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_CLEAR;
		calm = 1'b0;
		sent = 0;
		cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The matrix right after reset reads as cleared.
		send_item(ACT_QUERY, 4'd0, 4'd15, 16'd0);
		send_item(ACT_QUERY, 4'd15, 4'd0, 16'hFFFF);
		// A weight of infinity removes the edge; a self loop writes the diagonal.
		send_item(ACT_LOAD, 4'd0, 4'd1, INF);
		send_item(ACT_QUERY, 4'd0, 4'd1, 16'd0);
		send_item(ACT_LOAD, 4'd0, 4'd1, 16'd5);
		send_item(ACT_LOAD, 4'd1, 4'd2, dist_t'(INF - 1'b1));
		send_item(ACT_LOAD, 4'd2, 4'd3, 16'd0);
		send_item(ACT_LOAD, 4'd15, 4'd15, 16'd9);
		send_item(ACT_LOAD, 4'd3, 4'd15, 16'd7);
		send_item(ACT_RUN, 4'd0, 4'd0, 16'd0);
		// Path sums that reach infinity saturate.
		send_item(ACT_QUERY, 4'd0, 4'd2, 16'd0);
		send_item(ACT_QUERY, 4'd0, 4'd3, 16'd0);
		send_item(ACT_QUERY, 4'd2, 4'd15, 16'd0);
		send_item(ACT_QUERY, 4'd15, 4'd15, 16'd0);
		send_item(ACT_QUERY, 4'd1, 4'd0, 16'd0);
		send_item(ACT_CLEAR, 4'd15, 4'd15, 16'hFFFF);
		send_item(ACT_QUERY, 4'd15, 4'd15, 16'd0);

		// A count of zero acts as one; loads beyond the count are still stored.
		set_vertex_count(5'd0);
		send_item(ACT_LOAD, 4'd3, 4'd4, 16'd2);
		send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
		send_item(ACT_QUERY, 4'd0, 4'd3, 16'd0);
		send_item(ACT_QUERY, 4'd3, 4'd4, 16'd0);
		send_item(ACT_RUN, 4'd0, 4'd0, 16'd0);
		// A count above the maximum acts as the maximum.
		set_vertex_count(5'd31);
		send_item(ACT_RUN, 4'd0, 4'd0, 16'd0);
		send_item(ACT_QUERY, 4'd3, 4'd4, 16'd0);

		for (p = 0; p < 14; p++) begin
			set_vertex_count(phase_counts[p]);
			calm = ($urandom_range(0, 3) == 0);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				run_episode();
			end
		end

		s_tvalid <= 1'b0;
		wait_idle();
		repeat (64) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("all_pairs_shortest_path_core_tb OK");
		end else begin
			$display("all_pairs_shortest_path_core_tb NOT OK");
		end
		$finish;
	end

endmodule
